/* hdl/qpve_pkg.sv */
// shared types, constants and helpers for the quad primitive vertex expander
package qpve_pkg;

  localparam int MaxQuads = 16384;
  localparam int CountLimitInt = (6 * MaxQuads > 131071) ? 131071 : 6 * MaxQuads;
  localparam logic [16:0] COUNT_LIMIT = 17'(CountLimitInt);
  localparam logic [16:0] QUAD_INDICES = 17'd6;
  localparam logic signed [31:0] ONE_Q16 = 32'sh00010000;
  localparam int MatrixDepth = 12;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_FILL    = 3'd1,
    OP_LINE    = 3'd2,
    OP_OUTLINE = 3'd3,
    OP_SPRITE  = 3'd4,
    OP_FLUSH   = 3'd5
  } op_t;

  typedef struct packed {
    logic        [2:0]  op;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] xr;
    logic signed [31:0] yb;
    logic signed [31:0] z;
    logic        [31:0] color;
    logic        [30:0] t;
    logic        [3:0]  slot;
    logic signed [31:0] mval;
  } job_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQA, N_SQB, N_ROOT, N_MUL, N_DIV, N_DONE
  } norm_state_t;

  typedef enum logic [2:0] {
    B_IDLE, B_SEG, B_NWAIT, B_VTX, B_MUL, B_OUT
  } back_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -50'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

/* hdl/qpve_front.sv */
// command intake: saturated corner coordinates and a two-entry command queue
module qpve_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic        [2:0]   operation,
  input  logic signed [31:0]  ax,
  input  logic signed [31:0]  ay,
  input  logic signed [31:0]  bx,
  input  logic signed [31:0]  by,
  input  logic signed [31:0]  depth_z,
  input  logic        [31:0]  color,
  input  logic        [30:0]  thickness,
  input  logic        [3:0]   matrix_slot,
  input  logic signed [31:0]  matrix_value,
  input  logic                pop,
  output logic                job_valid,
  output qpve_pkg::job_t      job
);

  qpve_pkg::job_t q [2];
  qpve_pkg::job_t incoming;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       accept;

  assign in_stall  = (cnt == 2'd2);
  assign accept    = in_valid && !in_stall;
  assign job_valid = (cnt != 2'd0);
  assign job       = q[rd_ptr];

  always_comb begin
    incoming.op    = operation;
    incoming.ax    = ax;
    incoming.ay    = ay;
    incoming.bx    = bx;
    incoming.by    = by;
    incoming.xr    = qpve_pkg::sat32(50'(ax) + 50'(bx));
    incoming.yb    = qpve_pkg::sat32(50'(ay) + 50'(by));
    incoming.z     = depth_z;
    incoming.color = color;
    incoming.t     = thickness;
    incoming.slot  = matrix_slot;
    incoming.mval  = matrix_value;
  end

  always_ff @(posedge clk) begin
    if (accept) q[wr_ptr] <= incoming;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (accept) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + 2'(accept) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> cnt != 2'd0)
    else $error("pop from empty queue");
`endif

endmodule

/* hdl/qpve_normal.sv */
// line normal unit: normalize, iterative square root, two restoring divisions
module qpve_normal (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  x0,
  input  logic signed [31:0]  y0,
  input  logic signed [31:0]  x1,
  input  logic signed [31:0]  y1,
  input  logic        [30:0]  t,
  output logic                done,
  output logic signed [32:0]  nx,
  output logic signed [32:0]  ny
);

  qpve_pkg::norm_state_t state, state_next;

  logic signed [32:0] dxw, dyw;
  logic [32:0] mag_x, mag_y, m;
  logic neg_x, neg_y, comp;
  logic [61:0] sq;
  logic [63:0] s_rem, root, bitv, trial_r;
  logic [61:0] prod, p;
  logic [32:0] rem, trial;
  logic [31:0] quo, qf;
  logic [4:0]  iter;
  logic        qbit;
  logic        zero_len;

  assign dxw      = 33'(y1) - 33'(y0);
  assign dyw      = 33'(x0) - 33'(x1);
  assign zero_len = (dxw == 33'sd0) && (dyw == 33'sd0);
  assign m        = (mag_x > mag_y) ? mag_x : mag_y;
  assign trial_r  = root + bitv;
  assign p        = 62'(comp ? mag_y[30:0] : mag_x[30:0]) * 62'(t);
  assign trial    = {rem[31:0], prod[31]};
  assign qbit     = (trial >= {1'b0, root[31:0]});
  assign qf       = {quo[30:0], qbit};

  always_comb begin
    state_next = state;
    case (state)
      qpve_pkg::N_IDLE:  if (start) state_next = zero_len ? qpve_pkg::N_DONE : qpve_pkg::N_SHIFT;
      qpve_pkg::N_SHIFT: if (m[32:31] == 2'b00 && m[30]) state_next = qpve_pkg::N_SQA;
      qpve_pkg::N_SQA:   state_next = qpve_pkg::N_SQB;
      qpve_pkg::N_SQB:   state_next = qpve_pkg::N_ROOT;
      qpve_pkg::N_ROOT:  if (bitv == 64'd1) state_next = qpve_pkg::N_MUL;
      qpve_pkg::N_MUL:   state_next = qpve_pkg::N_DIV;
      qpve_pkg::N_DIV:   if (iter == 5'd31) state_next = comp ? qpve_pkg::N_DONE : qpve_pkg::N_MUL;
      qpve_pkg::N_DONE:  state_next = qpve_pkg::N_IDLE;
      default:           state_next = qpve_pkg::N_IDLE;
    endcase
  end

  always_comb begin
    done = (state == qpve_pkg::N_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= qpve_pkg::N_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      qpve_pkg::N_IDLE: begin
        if (start) begin
          neg_x <= dxw[32];
          neg_y <= dyw[32];
          mag_x <= dxw[32] ? 33'(-dxw) : 33'(dxw);
          mag_y <= dyw[32] ? 33'(-dyw) : 33'(dyw);
          nx    <= 33'sd0;
          ny    <= 33'sd0;
          comp  <= 1'b0;
        end
      end
      qpve_pkg::N_SHIFT: begin
        if (m[32:31] != 2'b00) begin
          mag_x <= mag_x >> 1;
          mag_y <= mag_y >> 1;
        end else if (!m[30]) begin
          mag_x <= mag_x << 1;
          mag_y <= mag_y << 1;
        end
      end
      qpve_pkg::N_SQA: sq <= 62'(mag_x[30:0]) * 62'(mag_x[30:0]);
      qpve_pkg::N_SQB: begin
        s_rem <= 64'(sq) + 64'(62'(mag_y[30:0]) * 62'(mag_y[30:0]));
        root  <= 64'd0;
        bitv  <= 64'd1 << 62;
      end
      qpve_pkg::N_ROOT: begin
        if (s_rem >= trial_r) begin
          s_rem <= s_rem - trial_r;
          root  <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
      end
      qpve_pkg::N_MUL: begin
        prod <= p;
        rem  <= {3'b000, p[61:32]};
        quo  <= 32'd0;
        iter <= 5'd0;
      end
      qpve_pkg::N_DIV: begin
        rem  <= qbit ? (trial - {1'b0, root[31:0]}) : trial;
        quo  <= qf;
        prod <= prod << 1;
        iter <= iter + 5'd1;
        if (iter == 5'd31) begin
          if (!comp) begin
            nx   <= neg_x ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
            comp <= 1'b1;
          end else begin
            ny <= neg_y ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
          end
        end
      end
      default: ;
    endcase
  end

endmodule

/* hdl/qpve_back.sv */
// vertex sequencer: segments, quad vertices, transform multiply-accumulate, output register
module qpve_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                job_valid,
  input  qpve_pkg::job_t      job,
  output logic                pop,
  output logic                n_start,
  output logic signed [31:0]  sx0,
  output logic signed [31:0]  sy0,
  output logic signed [31:0]  sx1,
  output logic signed [31:0]  sy1,
  output logic        [30:0]  n_t,
  input  logic                n_done,
  input  logic signed [32:0]  n_x,
  input  logic signed [32:0]  n_y,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  pos_x,
  output logic signed [31:0]  pos_y,
  output logic signed [31:0]  pos_z,
  output logic signed [31:0]  pos_w,
  output logic        [31:0]  vertex_color,
  output logic        [16:0]  index_total,
  output logic                count_full,
  output logic                last
);

  qpve_pkg::back_state_t state, state_next;
  qpve_pkg::job_t cur;

  logic signed [31:0] matrix [qpve_pkg::MatrixDepth];
  logic signed [31:0] res [4];
  logic [1:0] seg, vtx, row, col;
  logic signed [32:0] nxr, nyr;
  logic signed [31:0] vx, vy, mval;
  logic signed [63:0] prod;
  logic signed [49:0] acc, sum;
  logic signed [34:0] cx, cy;
  logic [16:0] count;
  logic [17:0] count_add;
  logic [3:0]  midx;
  logic        is_line, final_vtx, out_load;

  assign is_line   = (cur.op == qpve_pkg::OP_LINE) || (cur.op == qpve_pkg::OP_OUTLINE);
  assign final_vtx = (vtx == 2'd3) && ((cur.op != qpve_pkg::OP_OUTLINE) || (seg == 2'd3));
  assign midx      = 4'({2'b00, row} * 4'd3) + {2'b00, col};
  assign mval      = matrix[midx];
  assign count_add = {1'b0, count} + {1'b0, qpve_pkg::QUAD_INDICES};
  assign sum       = acc + 50'(prod >>> 16) + 50'(mval);
  assign n_t       = cur.t;

  // segment endpoints
  always_comb begin
    sx0 = cur.ax; sy0 = cur.ay; sx1 = cur.bx; sy1 = cur.by;
    if (cur.op == qpve_pkg::OP_OUTLINE) begin
      case (seg)
        2'd0: begin sx0 = cur.ax; sy0 = cur.ay; sx1 = cur.xr; sy1 = cur.ay; end
        2'd1: begin sx0 = cur.xr; sy0 = cur.ay; sx1 = cur.xr; sy1 = cur.yb; end
        2'd2: begin sx0 = cur.xr; sy0 = cur.yb; sx1 = cur.ax; sy1 = cur.yb; end
        default: begin sx0 = cur.ax; sy0 = cur.yb; sx1 = cur.ax; sy1 = cur.ay; end
      endcase
    end
  end

  // corner of the current vertex
  always_comb begin
    if (is_line) begin
      case (vtx)
        2'd0: begin cx = 35'(sx0) + 35'(nxr); cy = 35'(sy0) + 35'(nyr); end
        2'd1: begin cx = 35'(sx1) + 35'(nxr); cy = 35'(sy1) + 35'(nyr); end
        2'd2: begin cx = 35'(sx1) - 35'(nxr); cy = 35'(sy1) - 35'(nyr); end
        default: begin cx = 35'(sx0) - 35'(nxr); cy = 35'(sy0) - 35'(nyr); end
      endcase
    end else begin
      case (vtx)
        2'd0: begin cx = 35'(cur.ax); cy = 35'(cur.ay); end
        2'd1: begin cx = 35'(cur.xr); cy = 35'(cur.ay); end
        2'd2: begin cx = 35'(cur.xr); cy = 35'(cur.yb); end
        default: begin cx = 35'(cur.ax); cy = 35'(cur.yb); end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      qpve_pkg::B_IDLE: begin
        if (job_valid) begin
          case (job.op)
            qpve_pkg::OP_FILL, qpve_pkg::OP_SPRITE: state_next = qpve_pkg::B_VTX;
            qpve_pkg::OP_LINE, qpve_pkg::OP_OUTLINE: state_next = qpve_pkg::B_SEG;
            default: state_next = qpve_pkg::B_IDLE;
          endcase
        end
      end
      qpve_pkg::B_SEG:   state_next = qpve_pkg::B_NWAIT;
      qpve_pkg::B_NWAIT: if (n_done) state_next = qpve_pkg::B_VTX;
      qpve_pkg::B_VTX:   state_next = (cur.op == qpve_pkg::OP_SPRITE) ? qpve_pkg::B_OUT
                                                                      : qpve_pkg::B_MUL;
      qpve_pkg::B_MUL:   if (col == 2'd2 && row == 2'd3) state_next = qpve_pkg::B_OUT;
      qpve_pkg::B_OUT: begin
        if (out_load) begin
          if (vtx != 2'd3) state_next = qpve_pkg::B_VTX;
          else if (final_vtx) state_next = qpve_pkg::B_IDLE;
          else state_next = qpve_pkg::B_SEG;
        end
      end
      default: state_next = qpve_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop      = (state == qpve_pkg::B_IDLE) && job_valid;
    n_start  = (state == qpve_pkg::B_SEG);
    out_load = (state == qpve_pkg::B_OUT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= qpve_pkg::B_IDLE;
    else state <= state_next;
  end

  // control: count, matrix, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= 17'd0;
      out_valid <= 1'b0;
      for (int i = 0; i < qpve_pkg::MatrixDepth; i++) matrix[i] <= 32'sd0;
      matrix[0]  <= qpve_pkg::ONE_Q16;
      matrix[4]  <= qpve_pkg::ONE_Q16;
      matrix[11] <= qpve_pkg::ONE_Q16;
    end else begin
      if (pop && job.op == qpve_pkg::OP_LOAD && job.slot < 4'(qpve_pkg::MatrixDepth))
        matrix[job.slot] <= job.mval;
      if (pop && job.op == qpve_pkg::OP_FLUSH) count <= 17'd0;
      if (state == qpve_pkg::B_VTX && vtx == 2'd0)
        count <= (count_add >= {1'b0, qpve_pkg::COUNT_LIMIT}) ? qpve_pkg::COUNT_LIMIT
                                                              : count_add[16:0];
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      qpve_pkg::B_IDLE: begin
        if (job_valid) begin
          cur <= job;
          seg <= 2'd0;
          vtx <= 2'd0;
          nxr <= 33'sd0;
          nyr <= 33'sd0;
        end
      end
      qpve_pkg::B_NWAIT: begin
        if (n_done) begin
          nxr <= n_x;
          nyr <= n_y;
        end
      end
      qpve_pkg::B_VTX: begin
        vx  <= qpve_pkg::sat32(50'(cx));
        vy  <= qpve_pkg::sat32(50'(cy));
        row <= 2'd0;
        col <= 2'd0;
        res[0] <= qpve_pkg::sat32(50'(cx));
        res[1] <= qpve_pkg::sat32(50'(cy));
        res[2] <= (vtx == 2'd0) ? cur.z : 32'sd0;
        res[3] <= qpve_pkg::ONE_Q16;
      end
      qpve_pkg::B_MUL: begin
        case (col)
          2'd0: begin
            prod <= mval * vx;
            col  <= 2'd1;
          end
          2'd1: begin
            acc  <= 50'(prod >>> 16);
            prod <= mval * vy;
            col  <= 2'd2;
          end
          default: begin
            res[row] <= qpve_pkg::sat32(sum);
            col <= 2'd0;
            row <= row + 2'd1;
          end
        endcase
      end
      qpve_pkg::B_OUT: begin
        if (out_load) begin
          pos_x        <= res[0];
          pos_y        <= res[1];
          pos_z        <= res[2];
          pos_w        <= res[3];
          vertex_color <= cur.color;
          index_total  <= count;
          count_full   <= (count == qpve_pkg::COUNT_LIMIT);
          last         <= final_vtx;
          vtx          <= vtx + 2'd1;
          if (vtx == 2'd3) seg <= seg + 2'd1;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= qpve_pkg::COUNT_LIMIT)
    else $error("index count above limit");
  a_mul_col: assert property (@(posedge clk) disable iff (rst)
    (state == qpve_pkg::B_MUL) |-> (col != 2'd3))
    else $error("matrix column out of range");
`endif

endmodule

/* hdl/quad_primitive_vertex_expander_unit.sv */
// top level of the quad primitive vertex expander
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | operation, ax, ay, bx, by, depth_z, color,
//          |           |                      | thickness, matrix_slot, matrix_value
//  out     | output    | out_valid / out_stall| pos_x, pos_y, pos_z, pos_w, vertex_color,
//          |           |                      | index_total, count_full, last
//
// a transformed vertex runs twelve multiply-accumulate steps on the single 32x32 multiplier
// a line segment first computes its normal (a zero-length one skips straight to done): shift
// search, 32-step square root and two 33-step divisions; a rectangle outline runs this
// four times; a sprite vertex skips the transform multiply
// loads, flushes and unknown operations are popped without leaving the idle state of the sequencer
// reset is synchronous; the matrix returns to identity and the index count to zero
// a two-entry command queue and the output register let each side stall on its own
module quad_primitive_vertex_expander_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic        [2:0]   operation,
  input  logic signed [31:0]  ax,
  input  logic signed [31:0]  ay,
  input  logic signed [31:0]  bx,
  input  logic signed [31:0]  by,
  input  logic signed [31:0]  depth_z,
  input  logic        [31:0]  color,
  input  logic        [30:0]  thickness,
  input  logic        [3:0]   matrix_slot,
  input  logic signed [31:0]  matrix_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  pos_x,
  output logic signed [31:0]  pos_y,
  output logic signed [31:0]  pos_z,
  output logic signed [31:0]  pos_w,
  output logic        [31:0]  vertex_color,
  output logic        [16:0]  index_total,
  output logic                count_full,
  output logic                last
);

  qpve_pkg::job_t job;
  logic job_valid, pop, n_start, n_done;
  logic signed [31:0] sx0, sy0, sx1, sy1;
  logic [30:0] n_t;
  logic signed [32:0] n_x, n_y;

  qpve_front u_front (
    .clk, .rst, .in_valid, .in_stall, .operation, .ax, .ay, .bx, .by, .depth_z,
    .color, .thickness, .matrix_slot, .matrix_value, .pop, .job_valid, .job
  );

  qpve_normal u_normal (
    .clk, .rst, .start(n_start), .x0(sx0), .y0(sy0), .x1(sx1), .y1(sy1), .t(n_t),
    .done(n_done), .nx(n_x), .ny(n_y)
  );

  qpve_back u_back (
    .clk, .rst, .job_valid, .job, .pop, .n_start, .sx0, .sy0, .sx1, .sy1, .n_t,
    .n_done, .n_x, .n_y, .out_valid, .out_stall, .pos_x, .pos_y, .pos_z, .pos_w,
    .vertex_color, .index_total, .count_full, .last
  );

endmodule

/* dv/qpve_checker.sv */
// vertex predictor and output checker for the quad primitive vertex expander
`timescale 1ns / 100ps
module qpve_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic        [2:0]  operation,
  input  logic signed [31:0] ax,
  input  logic signed [31:0] ay,
  input  logic signed [31:0] bx,
  input  logic signed [31:0] by,
  input  logic signed [31:0] depth_z,
  input  logic        [31:0] color,
  input  logic        [30:0] thickness,
  input  logic        [3:0]  matrix_slot,
  input  logic signed [31:0] matrix_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [31:0] pos_w,
  input  logic        [31:0] vertex_color,
  input  logic        [16:0] index_total,
  input  logic               count_full,
  input  logic               last,
  output int                 pending,
  output int                 errors
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic        [31:0] col;
    logic        [16:0] total;
    logic               full;
    logic               lst;
  } vertex_t;

  vertex_t vertex_q[$];
  logic signed [31:0] xform[qpve_pkg::MatrixDepth];
  logic [16:0] quad_count;

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> 16;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] s);
    logic [63:0] r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > s) bt = bt >> 2;
    while (bt != 0) begin
      if (s >= r + bt) begin
        s = s - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  task automatic bump_count();
    if (quad_count + qpve_pkg::QUAD_INDICES >= qpve_pkg::COUNT_LIMIT)
      quad_count = qpve_pkg::COUNT_LIMIT;
    else quad_count = quad_count + qpve_pkg::QUAD_INDICES;
  endtask

  task automatic push_raw(input logic signed [63:0] x, input logic signed [63:0] y,
                          input logic signed [63:0] z, input logic signed [63:0] w,
                          input logic [31:0] c, input logic l);
    vertex_t v;
    v.x = x[31:0];
    v.y = y[31:0];
    v.z = z[31:0];
    v.w = w[31:0];
    v.col = c;
    v.total = quad_count;
    v.full = (quad_count == qpve_pkg::COUNT_LIMIT);
    v.lst = l;
    vertex_q.push_back(v);
  endtask

  task automatic push_xf(input logic signed [63:0] x, input logic signed [63:0] y,
                         input logic [31:0] c, input logic l);
    logic signed [63:0] r[4];
    x = clamp32(x);
    y = clamp32(y);
    for (int i = 0; i < 4; i++)
      r[i] = clamp32(fx_mul(xform[3*i], x) + fx_mul(xform[3*i+1], y) +
                     64'(xform[3*i+2]));
    push_raw(r[0], r[1], r[2], r[3], c, l);
  endtask

  task automatic predict_line(input logic signed [63:0] x0, input logic signed [63:0] y0,
                              input logic signed [63:0] x1, input logic signed [63:0] y1,
                              input logic [63:0] t, input logic [31:0] c, input logic l);
    logic signed [63:0] dx, dy, nx, ny;
    logic [63:0] mx, my, m, len;
    dx = y1 - y0;
    dy = x0 - x1;
    nx = 0;
    ny = 0;
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    m = mx > my ? mx : my;
    if (m != 0) begin
      while (m >= (64'd1 << 31)) begin
        mx = mx >> 1; my = my >> 1; m = m >> 1;
      end
      while (m < (64'd1 << 30)) begin
        mx = mx << 1; my = my << 1; m = m << 1;
      end
      len = int_sqrt(mx * mx + my * my);
      if (len != 0) begin
        nx = $signed(mx * t / len);
        ny = $signed(my * t / len);
      end
      if (dx < 0) nx = -nx;
      if (dy < 0) ny = -ny;
    end
    bump_count();
    push_xf(x0 + nx, y0 + ny, c, 1'b0);
    push_xf(x1 + nx, y1 + ny, c, 1'b0);
    push_xf(x1 - nx, y1 - ny, c, 1'b0);
    push_xf(x0 - nx, y0 - ny, c, l);
  endtask

  task automatic predict_command();
    logic signed [63:0] x, y, xr, yb;
    logic [63:0] t;
    x = 64'(ax);
    y = 64'(ay);
    xr = clamp32(x + 64'(bx));
    yb = clamp32(y + 64'(by));
    t = 64'(thickness);
    case (operation)
      qpve_pkg::OP_LOAD:
        if (matrix_slot < qpve_pkg::MatrixDepth) xform[matrix_slot] = matrix_value;
      qpve_pkg::OP_FILL: begin
        bump_count();
        push_xf(x, y, color, 1'b0);
        push_xf(xr, y, color, 1'b0);
        push_xf(xr, yb, color, 1'b0);
        push_xf(x, yb, color, 1'b1);
      end
      qpve_pkg::OP_LINE: predict_line(x, y, 64'(bx), 64'(by), t, color, 1'b1);
      qpve_pkg::OP_OUTLINE: begin
        predict_line(x, y, xr, y, t, color, 1'b0);
        predict_line(xr, y, xr, yb, t, color, 1'b0);
        predict_line(xr, yb, x, yb, t, color, 1'b0);
        predict_line(x, yb, x, y, t, color, 1'b1);
      end
      qpve_pkg::OP_SPRITE: begin
        bump_count();
        push_raw(x, y, 64'(depth_z), 64'(qpve_pkg::ONE_Q16), color, 1'b0);
        push_raw(xr, y, 0, 64'(qpve_pkg::ONE_Q16), color, 1'b0);
        push_raw(xr, yb, 0, 64'(qpve_pkg::ONE_Q16), color, 1'b0);
        push_raw(x, yb, 0, 64'(qpve_pkg::ONE_Q16), color, 1'b1);
      end
      qpve_pkg::OP_FLUSH: quad_count = '0;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    vertex_t exp_v, got;
    if (rst) begin
      for (int i = 0; i < qpve_pkg::MatrixDepth; i++) xform[i] = '0;
      xform[0] = qpve_pkg::ONE_Q16;
      xform[4] = qpve_pkg::ONE_Q16;
      xform[11] = qpve_pkg::ONE_Q16;
      quad_count = '0;
      vertex_q.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{pos_x, pos_y, pos_z, pos_w, vertex_color, index_total, count_full, last};
        if (vertex_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected vertex %h", got);
        end else begin
          exp_v = vertex_q.pop_front();
          if (got !== exp_v) begin
            errors++;
            if (errors <= 10)
              $display("vertex mismatch: exp x=%h y=%h z=%h w=%h c=%h n=%0d f=%b l=%b",
                       exp_v.x, exp_v.y, exp_v.z, exp_v.w, exp_v.col, exp_v.total,
                       exp_v.full, exp_v.lst,
                       "\n                 got x=%h y=%h z=%h w=%h c=%h n=%0d f=%b l=%b",
                       got.x, got.y, got.z, got.w, got.col, got.total, got.full,
                       got.lst);
          end
        end
      end
      if (in_valid && !in_stall) predict_command();
    end
    pending = vertex_q.size();
  end

endmodule

/* dv/tb_quad_primitive_vertex_expander_unit.sv */
// stimulus and verdict for the quad primitive vertex expander testbench
`timescale 1ns / 100ps
module tb_quad_primitive_vertex_expander_unit;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic        [2:0]  operation = '0;
  logic signed [31:0] ax = '0, ay = '0, bx = '0, by = '0, depth_z = '0;
  logic        [31:0] color = '0;
  logic        [30:0] thickness = '0;
  logic        [3:0]  matrix_slot = '0;
  logic signed [31:0] matrix_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] pos_x, pos_y, pos_z, pos_w;
  logic        [31:0] vertex_color;
  logic        [16:0] index_total;
  logic               count_full, last;
  int                 pending, errors;
  int                 send_idle = 0, recv_idle = 0;

  always #4 clk = ~clk;

  quad_primitive_vertex_expander_unit u_dut (.*);

  qpve_checker u_checker (.*);

  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle);

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return $urandom();
      default: return 32'($signed($urandom_range(2000)) - 1000) <<< 16 |
                      $urandom_range(65535);
    endcase
  endfunction

  task automatic send(input qpve_pkg::op_t op, input logic [31:0] a0,
                      input logic [31:0] a1,
                      input logic [31:0] b0, input logic [31:0] b1,
                      input logic [30:0] t, input logic [3:0] slot,
                      input logic [31:0] mv);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    ax <= a0;
    ay <= a1;
    bx <= b0;
    by <= b1;
    depth_z <= $urandom();
    color <= $urandom();
    thickness <= t;
    matrix_slot <= slot;
    matrix_value <= mv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random();
    int r;
    r = $urandom_range(99);
    if (r < 8)
      send(qpve_pkg::OP_LOAD, 0, 0, 0, 0, 0, 4'($urandom_range(15)),
           $urandom_range(1) ? $urandom() : 32'($urandom_range(131072)));
    else if (r < 10) send(qpve_pkg::OP_FLUSH, 0, 0, 0, 0, 0, 0, 0);
    else if (r < 12)
      send(qpve_pkg::op_t'(3'd6 + 3'($urandom_range(1))), 0, 0, 0, 0, 0, 0, 0);
    else
      send(qpve_pkg::op_t'(3'd1 + 3'($urandom_range(3))), pick_coord(), pick_coord(),
           pick_coord(), pick_coord(),
           31'($urandom_range(1) ? $urandom() : $urandom_range(1 << 20)),
           4'($urandom()), $urandom());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send(qpve_pkg::OP_FILL, 32'h00010000, 32'h00020000, 32'h00030000, 32'h00040000,
         0, 0, 0);
    send(qpve_pkg::OP_SPRITE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
         0, 0, 0);
    send(qpve_pkg::OP_LINE, 32'h00050000, 32'h00050000, 32'h00050000, 32'h00050000,
         31'h00010000, 0, 0);
    send(qpve_pkg::OP_LINE, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
         31'h7FFFFFFF, 0, 0);
    send(qpve_pkg::OP_OUTLINE, 32'hFFFF0000, 32'h00010000, 32'h00100000, 32'hFFF00000,
         31'h00008000, 0, 0);
    send(qpve_pkg::OP_OUTLINE, 0, 0, 0, 0, 31'h7FFFFFFF, 0, 0);
    send(qpve_pkg::OP_LOAD, 0, 0, 0, 0, 0, 4'd1, 32'h00008000);
    send(qpve_pkg::OP_LOAD, 0, 0, 0, 0, 0, 4'd5, 32'h80000000);
    send(qpve_pkg::OP_LOAD, 0, 0, 0, 0, 0, 4'd8, 32'h7FFFFFFF);
    send(qpve_pkg::OP_LOAD, 0, 0, 0, 0, 0, 4'd15, 32'hFFFFFFFF);
    send(qpve_pkg::OP_FILL, 32'hFFFFFFFF, 32'h00000001, 32'h7FFFFFFF, 32'h80000000,
         0, 0, 0);
    send(qpve_pkg::op_t'(3'd6), 0, 0, 0, 0, 0, 0, 0);
    send(qpve_pkg::op_t'(3'd7), 0, 0, 0, 0, 0, 0, 0);
    send(qpve_pkg::OP_FLUSH, 0, 0, 0, 0, 0, 0, 0);
    send(qpve_pkg::OP_SPRITE, 32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000,
         0, 0, 0);
    drain();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 23 : (phase == 1) ? 54 : 0;
      recv_idle = (phase == 0) ? 54 : (phase == 1) ? 23 : 0;
      for (int i = 0; i < 30; i++) send_random();
      drain();
    end
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
